// ----- rtl/mgcs_pkg.sv -----
// ----------------------------------------------------------------------------
// mgcs_pkg: shared types and constants for the coarse search core
// Phase encoding, operation codes, result flag bundle and code-field constants.
// ----------------------------------------------------------------------------
package mgcs_pkg;

  // Fixed field widths
  localparam int StartWidth = 16;
  localparam int IterWidth  = 4;
  localparam int CodeWidth  = 16;
  localparam int MagWidth   = 6;

  // Sign-magnitude code constants
  localparam logic [CodeWidth-1:0] SmSignBit = 16'h0040;
  localparam logic [MagWidth-1:0]  SmMagMax  = 6'd63;

  // Operation codes of an input word
  typedef enum logic {
    OpStart = 1'b0,
    OpRead  = 1'b1
  } op_e;

  // Search phase, one-hot
  typedef enum logic [5:0] {
    PhIdle      = 6'b000001,
    PhRoundUp   = 6'b000010,
    PhRoundDown = 6'b000100,
    PhFinUp     = 6'b001000,
    PhFinDown   = 6'b010000,
    PhFinLast   = 6'b100000
  } phase_e;

  // Result flags
  typedef struct packed {
    logic apply;
    logic measure;
    logic done_res;
  } flags_t;

endpackage

// ----- rtl/mgcs_if.sv -----
// ----------------------------------------------------------------------------
// mgcs_if: channel interfaces of the coarse search core
// Input word, result word and configuration write channels, valid/ready.
// ----------------------------------------------------------------------------
interface mgcs_item_if #(
  parameter int RSSI_WIDTH = 18
);
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic signed [mgcs_pkg::StartWidth-1:0] start_value;
  logic [mgcs_pkg::IterWidth-1:0]     iterations;
  logic [RSSI_WIDTH-1:0]              rssi;

  modport source (output valid, op, start_value, iterations, rssi, input ready);
  modport sink   (input valid, op, start_value, iterations, rssi, output ready);
endinterface

interface mgcs_result_if #(
  parameter int VALUE_WIDTH = 16
);
  logic                              valid;
  logic                              ready;
  logic signed [VALUE_WIDTH-1:0]     setting;
  logic [mgcs_pkg::CodeWidth-1:0]    setting_code;
  logic                              apply;
  logic                              measure;
  logic                              done_res;

  modport source (output valid, setting, setting_code, apply, measure, done_res,
                  input ready);
  modport sink   (input valid, setting, setting_code, apply, measure, done_res,
                  output ready);
endinterface

interface mgcs_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/measurement_guided_coarse_search_core.sv -----
// ----------------------------------------------------------------------------
// measurement_guided_coarse_search_core: RSSI-guided coarse search
// Binary-style search over a signed setting driven by one reading per step.
// ----------------------------------------------------------------------------
// Each accepted word (start or reading) updates the search state and puts
// its result word into the output buffer at the accepting edge. A new word
// can be taken every cycle while input ready is high; the two-entry output
// buffer keeps a word pushed under an output stall in its second entry and
// drops input ready only while both entries are full. Readings that arrive
// with no search running are accepted and give no result. The mode register
// may be written at any time and affects codes of results formed afterwards.
module measurement_guided_coarse_search_core #(
  parameter int VALUE_WIDTH = 16,
  parameter int RSSI_WIDTH  = 18
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mgcs_item_if.sink         item_i,
  mgcs_result_if.source     result_o,
  mgcs_cfg_if.sink          cfg_i
);

  localparam int PackWidth = VALUE_WIDTH + mgcs_pkg::CodeWidth + 3;

  logic                            sm_mode_q;
  logic                            fire, space, res_valid;
  logic [VALUE_WIDTH-1:0]          res_setting;
  mgcs_pkg::flags_t                res_flags, out_flags;
  logic [mgcs_pkg::CodeWidth-1:0]  res_code;
  logic [PackWidth-1:0]            pack_in, pack_out;

  // Configuration register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sm_mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      sm_mode_q <= cfg_i.data;
    end
  end

  // Input handshake
  assign item_i.ready = space;
  assign fire         = item_i.valid && space;

  mgcs_engine #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .RSSI_WIDTH  (RSSI_WIDTH)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .op_i          (item_i.op),
    .start_value_i (item_i.start_value),
    .iterations_i  (item_i.iterations),
    .rssi_i        (item_i.rssi),
    .res_valid_o   (res_valid),
    .res_setting_o (res_setting),
    .res_flags_o   (res_flags)
  );

  mgcs_code #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_code (
    .sm_mode_i (sm_mode_q),
    .setting_i (res_setting),
    .code_o    (res_code)
  );

  // Pack result word into the output buffer
  assign pack_in = {res_setting, res_code, res_flags};

  mgcs_skid #(
    .WIDTH (PackWidth)
  ) u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (pack_in),
    .space_o (space),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .data_o  (pack_out)
  );

  // Unpack result word
  assign out_flags             = pack_out[2:0];
  assign result_o.setting      = pack_out[PackWidth-1 -: VALUE_WIDTH];
  assign result_o.setting_code = pack_out[mgcs_pkg::CodeWidth+2 -: mgcs_pkg::CodeWidth];
  assign result_o.apply        = out_flags.apply;
  assign result_o.measure      = out_flags.measure;
  assign result_o.done_res     = out_flags.done_res;

endmodule

// ----- rtl/mgcs_engine.sv -----
// ----------------------------------------------------------------------------
// mgcs_engine: search state and step update
// Updates the search state on each accepted word and forms its result word, if it gives one.
// ----------------------------------------------------------------------------
module mgcs_engine #(
  parameter int VALUE_WIDTH = 16,
  parameter int RSSI_WIDTH  = 18
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                fire_i,
  input  logic                                op_i,
  input  logic signed [mgcs_pkg::StartWidth-1:0] start_value_i,
  input  logic [mgcs_pkg::IterWidth-1:0]      iterations_i,
  input  logic [RSSI_WIDTH-1:0]               rssi_i,
  output logic                                res_valid_o,
  output logic [VALUE_WIDTH-1:0]              res_setting_o,
  output mgcs_pkg::flags_t                    res_flags_o
);

  localparam logic [VALUE_WIDTH-1:0] One = VALUE_WIDTH'(1);

  mgcs_pkg::phase_e                  phase_q, phase_d;
  logic [VALUE_WIDTH-1:0]            trial_q, trial_d;
  logic [RSSI_WIDTH-1:0]             ref_q, ref_d;
  logic [mgcs_pkg::IterWidth-1:0]    round_q, round_d;
  logic [mgcs_pkg::IterWidth-1:0]    steps_q, steps_d;

  logic [mgcs_pkg::IterWidth-1:0]    exp0, exp1, exp2, round_inc, last_round;
  logic [VALUE_WIDTH-1:0]            pw0, pw1, pw2, fin_step, start_ext;
  logic                              ref_lower;

  // Step sizes of the current round
  assign exp0       = steps_q - round_q;
  assign exp1       = exp0 - 4'd1;
  assign exp2       = exp0 - 4'd2;
  assign pw0        = One << exp0;
  assign pw1        = One << exp1;
  assign pw2        = One << exp2;
  assign fin_step   = (steps_q == '0) ? One : (One << 1);
  assign round_inc  = round_q + 4'd1;
  assign last_round = steps_q - 4'd1;
  assign ref_lower  = ref_q < rssi_i;
  assign start_ext  = VALUE_WIDTH'(start_value_i);

  // Next state and result word
  always_comb begin
    phase_d       = phase_q;
    trial_d       = trial_q;
    ref_d         = ref_q;
    round_d       = round_q;
    steps_d       = steps_q;
    res_valid_o   = 1'b0;
    res_setting_o = trial_q;
    res_flags_o   = '{apply: 1'b1, measure: 1'b1, done_res: 1'b0};
    if (fire_i) begin
      if (op_i == mgcs_pkg::OpStart) begin
        trial_d       = start_ext;
        steps_d       = iterations_i;
        round_d       = '0;
        ref_d         = '0;
        phase_d       = (iterations_i > 4'd1) ? mgcs_pkg::PhRoundUp : mgcs_pkg::PhFinUp;
        res_valid_o   = 1'b1;
        res_setting_o = start_ext;
      end else begin
        unique case (phase_q)
          mgcs_pkg::PhRoundUp: begin
            ref_d         = rssi_i;
            trial_d       = trial_q - pw0;
            phase_d       = mgcs_pkg::PhRoundDown;
            res_valid_o   = 1'b1;
            res_setting_o = trial_d;
          end
          mgcs_pkg::PhRoundDown: begin
            if (ref_q >= rssi_i) begin
              trial_d = trial_q + pw2;
            end else begin
              trial_d = trial_q + pw0 + pw1 - pw2;
            end
            round_d       = round_inc;
            phase_d       = (round_inc < last_round) ? mgcs_pkg::PhRoundUp
                                                     : mgcs_pkg::PhFinUp;
            res_valid_o   = 1'b1;
            res_setting_o = trial_d;
          end
          mgcs_pkg::PhFinUp: begin
            ref_d         = rssi_i;
            trial_d       = trial_q - fin_step;
            phase_d       = mgcs_pkg::PhFinDown;
            res_valid_o   = 1'b1;
            res_setting_o = trial_q - (fin_step << 1);
          end
          mgcs_pkg::PhFinDown: begin
            if (ref_lower) begin
              trial_d = trial_q + One;
            end
            phase_d       = mgcs_pkg::PhFinLast;
            res_valid_o   = 1'b1;
            res_setting_o = trial_d;
          end
          mgcs_pkg::PhFinLast: begin
            if (ref_lower) begin
              trial_d = trial_q + One;
            end
            phase_d       = mgcs_pkg::PhIdle;
            res_valid_o   = 1'b1;
            res_setting_o = trial_d;
            res_flags_o   = '{apply: ref_lower, measure: 1'b0, done_res: 1'b1};
          end
          default: begin
            // drop readings while idle
            phase_d = mgcs_pkg::PhIdle;
          end
        endcase
      end
    end
  end

  // Hold state between words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mgcs_pkg::PhIdle;
      trial_q <= '0;
      ref_q   <= '0;
      round_q <= '0;
      steps_q <= '0;
    end else begin
      phase_q <= phase_d;
      trial_q <= trial_d;
      ref_q   <= ref_d;
      round_q <= round_d;
      steps_q <= steps_d;
    end
  end

  // A start always moves into the rounds or the final phase
  a_start_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && op_i == mgcs_pkg::OpStart) |=>
      (phase_q == mgcs_pkg::PhRoundUp || phase_q == mgcs_pkg::PhFinUp))
    else $error("start did not enter a search phase");

  // A reading while idle gives no result and leaves the block idle
  a_idle_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && op_i == mgcs_pkg::OpRead && phase_q == mgcs_pkg::PhIdle) |->
      (!res_valid_o && phase_d == mgcs_pkg::PhIdle))
    else $error("reading while idle produced a result");

  // The final result requests no further reading and ends the search
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_flags_o.done_res) |->
      (!res_flags_o.measure && phase_d == mgcs_pkg::PhIdle))
    else $error("final result did not end the search");

endmodule

// ----- rtl/mgcs_code.sv -----
// ----------------------------------------------------------------------------
// mgcs_code: setting code encoder
// Maps a setting to two's complement bits or saturated 7-bit sign-magnitude.
// ----------------------------------------------------------------------------
module mgcs_code #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                             sm_mode_i,
  input  logic [VALUE_WIDTH-1:0]           setting_i,
  output logic [mgcs_pkg::CodeWidth-1:0]   code_o
);

  logic                                    neg;
  logic [VALUE_WIDTH-1:0]                  mag_full;
  logic [mgcs_pkg::MagWidth-1:0]           mag;
  logic [VALUE_WIDTH+mgcs_pkg::CodeWidth-1:0] raw;

  // Magnitude, saturated to the code field
  assign neg      = setting_i[VALUE_WIDTH-1];
  assign mag_full = neg ? (~setting_i + VALUE_WIDTH'(1)) : setting_i;
  assign mag      = (mag_full > VALUE_WIDTH'(mgcs_pkg::SmMagMax)) ? mgcs_pkg::SmMagMax
                                                                   : mag_full[5:0];
  assign raw      = {{mgcs_pkg::CodeWidth{1'b0}}, setting_i};

  // Select the code form
  always_comb begin
    if (sm_mode_i) begin
      code_o = (neg ? mgcs_pkg::SmSignBit : '0) | mgcs_pkg::CodeWidth'(mag);
    end else begin
      code_o = raw[mgcs_pkg::CodeWidth-1:0];
    end
  end

endmodule

// ----- rtl/mgcs_skid.sv -----
// ----------------------------------------------------------------------------
// mgcs_skid: two-entry output buffer
// Result register plus a skid register so input can be taken under a stall.
// ----------------------------------------------------------------------------
module mgcs_skid #(
  parameter int WIDTH = 35
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             space_o,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  logic             main_v_q, skid_v_q;
  logic [WIDTH-1:0] main_q, skid_q;
  logic             pop;

  assign pop     = main_v_q && ready_i;
  assign space_o = !skid_v_q;
  assign valid_o = main_v_q;
  assign data_o  = main_q;

  // Advance valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        main_v_q <= 1'b1;
      end
    end else if (pop) begin
      main_v_q <= 1'b0;
    end
  end

  // Move payload words
  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_v_q && !pop) begin
        skid_q <= data_i;
      end else begin
        main_q <= data_i;
      end
    end
  end

  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> main_v_q)
    else $error("skid entry held without a result entry");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && main_v_q && !ready_i) |=> skid_v_q)
    else $error("word pushed under stall was not kept");

endmodule

// ----- test/tb_measurement_guided_coarse_search_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_measurement_guided_coarse_search_core: self-checking bench of the search
// A short directed table opens the run, followed by random search sequences in
// both code modes. Every accepted input word is stepped through a local search
// predictor, and each result word is checked field by field against the
// oldest pending expectation. Both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_measurement_guided_coarse_search_core;

  localparam int RandItems    = 1525;
  localparam int SettleCycles = 8;
  localparam int CycleLimit   = 800000;
  localparam int ReportMax    = 10;

  typedef struct packed {
    mgcs_pkg::op_e      op;
    logic signed [15:0] start_value;
    logic [3:0]         iterations;
    logic [17:0]        rssi;
  } word_t;

  typedef struct packed {
    logic signed [15:0] setting;
    logic [15:0]        code;
    mgcs_pkg::flags_t   flags;
  } result_t;

  typedef enum logic {
    RowWord = 1'b0,
    RowMode = 1'b1
  } row_kind_e;

  typedef struct {
    row_kind_e kind;
    word_t     w;
    bit        typed;
    bit        has_res;
    result_t   res;
    bit        mode;
  } row_t;

  logic clk_i;
  logic rst_ni;

  mgcs_item_if #(.RSSI_WIDTH(18))    item_if ();
  mgcs_result_if #(.VALUE_WIDTH(16)) res_if ();
  mgcs_cfg_if                        cfg_if ();

  measurement_guided_coarse_search_core #(
    .VALUE_WIDTH(16),
    .RSSI_WIDTH (18)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(res_if),
    .cfg_i   (cfg_if)
  );

  // Search predictor state
  mgcs_pkg::phase_e   srch_phase = mgcs_pkg::PhIdle;
  logic signed [15:0] trial      = '0;
  logic [17:0]        ref_level  = '0;
  logic [3:0]         round_no   = '0;
  logic [3:0]         steps      = '0;
  logic               sm_mode    = 1'b0;

  result_t     pending_results[$];
  row_t        dir_rows[$];
  int          mismatches  = 0;
  int          items_sent  = 0;
  int          cycles      = 0;
  int          burst_left  = 0;
  logic [17:0] last_rssi   = '0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL measurement_guided_coarse_search_core");
      $finish;
    end
  end

  function automatic logic [15:0] pw2(input int e);
    return 16'(1) << e;
  endfunction

  // Build one result word, encoding the code field per mode
  function automatic result_t form_result(input logic signed [15:0] val, input logic ap,
                                          input logic ms, input logic dn);
    result_t r;
    int s;
    int mag;
    s   = val;
    mag = (s < 0) ? -s : s;
    if (mag > mgcs_pkg::SmMagMax) mag = mgcs_pkg::SmMagMax;
    r.setting = val;
    if (sm_mode) r.code = ((s < 0) ? mgcs_pkg::SmSignBit : 16'h0000) | 16'(mag);
    else r.code = val;
    r.flags.apply    = ap;
    r.flags.measure  = ms;
    r.flags.done_res = dn;
    return r;
  endfunction

  // Advance the search by one accepted word; return 1 when it yields a result
  function automatic bit search_step(input word_t w, output result_t r);
    logic [15:0] fs;
    int n;
    int k;
    n  = steps;
    k  = round_no;
    fs = (steps == 0) ? 16'd1 : 16'd2;
    r  = '0;
    if (w.op == mgcs_pkg::OpStart) begin
      trial      = w.start_value;
      steps      = w.iterations;
      round_no   = '0;
      ref_level  = '0;
      srch_phase = (w.iterations > 1) ? mgcs_pkg::PhRoundUp : mgcs_pkg::PhFinUp;
      r = form_result(trial, 1'b1, 1'b1, 1'b0);
      return 1'b1;
    end
    case (srch_phase)
      mgcs_pkg::PhRoundUp: begin
        ref_level  = w.rssi;
        trial      = trial - pw2(n - k);
        srch_phase = mgcs_pkg::PhRoundDown;
        r = form_result(trial, 1'b1, 1'b1, 1'b0);
      end
      mgcs_pkg::PhRoundDown: begin
        if (ref_level >= w.rssi) trial = trial + pw2(n - 2 - k);
        else trial = trial + pw2(n - k) + pw2(n - 1 - k) - pw2(n - 2 - k);
        round_no   = round_no + 4'd1;
        srch_phase = (int'(round_no) < n - 1) ? mgcs_pkg::PhRoundUp : mgcs_pkg::PhFinUp;
        r = form_result(trial, 1'b1, 1'b1, 1'b0);
      end
      mgcs_pkg::PhFinUp: begin
        ref_level  = w.rssi;
        trial      = trial - fs;
        srch_phase = mgcs_pkg::PhFinDown;
        r = form_result(trial - fs, 1'b1, 1'b1, 1'b0);
      end
      mgcs_pkg::PhFinDown: begin
        if (ref_level < w.rssi) trial = trial + 16'd1;
        srch_phase = mgcs_pkg::PhFinLast;
        r = form_result(trial, 1'b1, 1'b1, 1'b0);
      end
      mgcs_pkg::PhFinLast: begin
        srch_phase = mgcs_pkg::PhIdle;
        if (ref_level < w.rssi) begin
          trial = trial + 16'd1;
          r = form_result(trial, 1'b1, 1'b0, 1'b1);
        end else begin
          r = form_result(trial, 1'b0, 1'b0, 1'b1);
        end
      end
      default: begin
        // Reading with no search running: swallowed
        srch_phase = mgcs_pkg::PhIdle;
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void note_failure(input string what, input logic [31:0] want,
                                       input logic [31:0] got);
    if (mismatches < ReportMax)
      $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    mismatches++;
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) note_failure(what, want, got);
  endfunction

  // Gap length: mostly short, now and then long
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic row_t start_row(input int sv, input int n, input logic [15:0] code);
    row_t r;
    r.kind                 = RowWord;
    r.w.op                 = mgcs_pkg::OpStart;
    r.w.start_value        = 16'(sv);
    r.w.iterations         = 4'(n);
    r.w.rssi               = '0;
    r.typed                = 1'b1;
    r.has_res              = 1'b1;
    r.res.setting          = 16'(sv);
    r.res.code             = code;
    r.res.flags.apply      = 1'b1;
    r.res.flags.measure    = 1'b1;
    r.res.flags.done_res   = 1'b0;
    r.mode                 = 1'b0;
    return r;
  endfunction

  // A reading; with swallowed clear it is checked against the predictor, with
  // swallowed set the bench expects that no result follows
  function automatic row_t read_row(input int level, input bit swallowed);
    row_t r;
    r.kind          = RowWord;
    r.w.op          = mgcs_pkg::OpRead;
    r.w.start_value = '0;
    r.w.iterations  = '0;
    r.w.rssi        = 18'(level);
    r.typed         = swallowed;
    r.has_res       = 1'b0;
    r.res           = '0;
    r.mode          = 1'b0;
    return r;
  endfunction

  function automatic word_t make_start();
    word_t w;
    int p;
    int v;
    p = $urandom_range(0, 99);
    if (p < 30) v = $urandom_range(0, 65535);
    else if (p < 60) v = $urandom_range(0, 400) - 200;
    else if (p < 75) v = $urandom_range(0, 140) - 70;
    else if (p < 83) v = 32767 - $urandom_range(0, 40);
    else if (p < 91) v = $urandom_range(0, 40) - 32768;
    else v = $urandom_range(0, 65535);
    w.op          = mgcs_pkg::OpStart;
    w.start_value = 16'(v);
    w.iterations  = ($urandom_range(0, 99) < 5) ? 4'd0 : 4'($urandom_range(1, 12));
    w.rssi        = 18'($urandom_range(0, 262143));
    return w;
  endfunction

  function automatic word_t make_read();
    word_t w;
    int p;
    p = $urandom_range(0, 99);
    w.op          = mgcs_pkg::OpRead;
    w.start_value = 16'($urandom_range(0, 65535));
    w.iterations  = 4'($urandom_range(0, 15));
    if (p < 40) w.rssi = 18'($urandom_range(0, 262143));
    else if (p < 65) w.rssi = 18'($urandom_range(0, 15));
    else if (p < 80) w.rssi = last_rssi;
    else if (p < 90) w.rssi = ($urandom_range(0, 1) == 1) ? 18'h3FFFF : 18'h00000;
    else w.rssi = last_rssi + 18'($urandom_range(0, 2)) - 18'd1;
    return w;
  endfunction

  // Drive one input word, predict at acceptance, then idle or keep valid high
  task automatic send_word(input word_t w, input bit typed, input bit t_has,
                           input result_t t_res);
    result_t r;
    bit has;
    int g;
    item_if.valid       <= 1'b1;
    item_if.op          <= w.op;
    item_if.start_value <= w.start_value;
    item_if.iterations  <= w.iterations;
    item_if.rssi        <= w.rssi;
    do @(posedge clk_i); while (!item_if.ready);
    has = search_step(w, r);
    if (typed) begin
      has = t_has;
      r   = t_res;
    end
    if (has) pending_results.push_back(r);
    if (w.op == mgcs_pkg::OpRead) last_rssi = w.rssi;
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
      g = 0;
    end else begin
      g = gap_len();
      if ($urandom_range(0, 99) < 2) burst_left = $urandom_range(20, 60);
    end
    if (g > 0) begin
      item_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Drop input valid and wait for all pending results plus a short tail
  task automatic settle();
    item_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic m);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= m;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    sm_mode = m;
  endtask

  // Result side: ready stretches broken by random stalls
  initial begin
    int hold;
    int g;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = ($urandom_range(0, 99) < 15) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      res_if.ready <= 1'b1;
      repeat (hold) @(posedge clk_i);
      g = gap_len();
      if (g > 0) begin
        res_if.ready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
  end

  // Check each accepted result word against the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        note_failure("result word with none expected", '0, 32'(res_if.setting));
      end else begin
        want = pending_results.pop_front();
        check_field("setting", 32'(want.setting), 32'(res_if.setting));
        check_field("setting_code", 32'(want.code), 32'(res_if.setting_code));
        check_field("apply", 32'(want.flags.apply), 32'(res_if.apply));
        check_field("measure", 32'(want.flags.measure), 32'(res_if.measure));
        check_field("done_res", 32'(want.flags.done_res), 32'(res_if.done_res));
      end
    end
  end

  // Main stimulus
  initial begin
    row_t    r;
    word_t   w;
    result_t none;
    int      target;
    none = '0;

    rst_ni              <= 1'b0;
    item_if.valid       <= 1'b0;
    item_if.op          <= mgcs_pkg::OpStart;
    item_if.start_value <= '0;
    item_if.iterations  <= '0;
    item_if.rssi        <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.data         <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table, two's complement codes first
    dir_rows.push_back(read_row(262143, 1'b1));        // reading right after reset
    dir_rows.push_back(start_row(0, 1, 16'h0000));     // single step: final phase at once
    dir_rows.push_back(read_row(100, 1'b0));
    dir_rows.push_back(read_row(200, 1'b0));
    dir_rows.push_back(read_row(300, 1'b0));           // final with change
    dir_rows.push_back(read_row(7, 1'b1));             // reading after done
    dir_rows.push_back(start_row(32767, 12, 16'h7FFF));
    dir_rows.push_back(read_row(0, 1'b0));
    dir_rows.push_back(read_row(262143, 1'b0));
    dir_rows.push_back(start_row(-32768, 0, 16'h8000)); // restart while busy, zero steps
    dir_rows.push_back(read_row(5, 1'b0));
    dir_rows.push_back(read_row(5, 1'b0));
    dir_rows.push_back(read_row(5, 1'b0));             // final without change
    dir_rows.push_back(start_row(100, 2, 16'h0064));
    dir_rows.push_back(read_row(1000, 1'b0));
    dir_rows.push_back(read_row(10, 1'b0));
    dir_rows.push_back(read_row(3, 1'b0));
    dir_rows.push_back(read_row(9, 1'b0));
    dir_rows.push_back(read_row(2, 1'b0));
    // Switch to sign-magnitude codes
    r      = read_row(0, 1'b0);
    r.kind = RowMode;
    r.mode = 1'b1;
    dir_rows.push_back(r);
    dir_rows.push_back(start_row(-32768, 3, 16'h007F)); // magnitude saturates
    dir_rows.push_back(start_row(63, 1, 16'h003F));
    dir_rows.push_back(start_row(64, 8, 16'h003F));
    dir_rows.push_back(start_row(-1, 4, 16'h0041));
    dir_rows.push_back(start_row(-63, 2, 16'h007F));
    dir_rows.push_back(read_row(0, 1'b0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == RowMode) begin
        settle();
        write_mode(dir_rows[i].mode);
      end else begin
        send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].has_res, dir_rows[i].res);
      end
    end

    // Random search sequences, mode alternating per phase
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_mode(ph[0]);
      target = items_sent + RandItems / 4;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 4) begin
          send_word(make_read(), 1'b0, 1'b0, none);
        end else begin
          send_word(make_start(), 1'b0, 1'b0, none);
          while (srch_phase != mgcs_pkg::PhIdle && items_sent < target) begin
            // Abandon a search now and then
            if ($urandom_range(0, 99) < 2) break;
            w = make_read();
            send_word(w, 1'b0, 1'b0, none);
          end
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("PASS measurement_guided_coarse_search_core");
    end else begin
      $display("FAIL measurement_guided_coarse_search_core");
    end
    $finish;
  end

endmodule
